// ===== hdl/lpsr_pkg.sv =====
// lpsr_pkg: widths, register indexes, sideband type and the cordic angle table
// function shared by the sector and radius filter; depends on nothing
`default_nettype none

package lpsr_pkg;

    localparam int COORD_W      = 20;
    localparam int ANGLE_W      = 15;
    localparam int RADIUS_W     = 20;
    localparam int SQ_W         = 2 * COORD_W;
    localparam int SECTOR_CNT_W = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR0_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL_RADIUS  = 3'd7;

    localparam int CORDIC_ITERS = 48;
    localparam int PRE_SHIFT    = 40;
    localparam int ANG_FRAC     = 50;
    localparam int XW           = 62;
    localparam int ZW           = 64;
    localparam int ZB_W         = ZW - ANG_FRAC;
    localparam int OCT_W        = 12;
    localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C234;

    localparam int ANG_OCTANT  = 2880;
    localparam int ANG_QUARTER = 5760;
    localparam int ANG_HALF    = 11520;

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic swapped;
        logic by_radius;
    } t_side;

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // arctan(2^-idx) in units of 2^-50 of 1/64 degree
    function automatic logic [63:0] cordic_angle(input int idx);
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] rem;
        logic [63:0] quo;
        logic        carry;
        int          e;
        acc = '0;
        quo = '0;
        if (idx == 0) begin
            return 64'(ANG_OCTANT) << ANG_FRAC;
        end
        for (int k = 0; k < 32; k++) begin
            e = idx * (2 * k + 1);
            if (e <= 62) begin
                term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
                if ((k & 1) != 0) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
        end
        rem = acc;
        for (int b = 0; b < ANG_FRAC; b++) begin
            carry = rem[63];
            rem   = rem << 1;
            quo   = quo << 1;
            if (carry || rem >= PI_Q62) begin
                rem    = rem - PI_Q62;
                quo[0] = 1'b1;
            end
        end
        return quo * 64'(ANG_HALF);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/lidar_point_sector_radius_filter.sv =====
// lidar_point_sector_radius_filter: top level, configuration registers and pipeline
// pipeline: 54 register stages (3 prep, 48 cordic, 3 post); the result strobe is the last post valid register
// throughput: one point per clock outside reset, every stage is a plain register that never stalls
// busy is low except in reset; results cannot be stalled by the receiver
// synchronous reset clears all valid bits and sets every configuration register to zero
// depends on lpsr_pkg, lpsr_prep, lpsr_cordic, lpsr_post
`default_nettype none

module lidar_point_sector_radius_filter #(
    parameter int NUM_SECTORS = 3
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic signed [lpsr_pkg::COORD_W-1:0]    i_point_x,
    input  wire logic signed [lpsr_pkg::COORD_W-1:0]    i_point_y,
    output logic                                        o_result_valid,
    output logic                                        o_keep_point,
    output logic                                        o_dropped_by_sector,
    output logic                                        o_dropped_by_radius,
    output logic signed [lpsr_pkg::ANGLE_W-1:0]         o_bearing,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [lpsr_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [lpsr_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import lpsr_pkg::*;

    logic [SECTOR_CNT_W-1:0]   r_sector_count;
    logic signed [ANGLE_W-1:0] r_sec_lo [NUM_SECTORS];
    logic signed [ANGLE_W-1:0] r_sec_hi [NUM_SECTORS];
    logic [RADIUS_W-1:0]       r_radius;
    logic                      cfg_wr;
    logic                      in_take;

    logic                 prep_valid;
    logic [COORD_W-1:0]   prep_big, prep_small;
    t_side                prep_side;
    logic                 cord_valid;
    logic signed [ZW-1:0] cord_z;
    t_side                cord_side;

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign in_take     = start & ~busy;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_count <= '0;
            r_radius       <= '0;
            for (int s = 0; s < NUM_SECTORS; s++) begin
                r_sec_lo[s] <= '0;
                r_sec_hi[s] <= '0;
            end
        end else if (cfg_wr) begin
            if (i_cfg_index == CFG_SECTOR_COUNT) begin
                r_sector_count <= i_cfg_data[SECTOR_CNT_W-1:0];
            end
            if (i_cfg_index == CFG_EXCL_RADIUS) begin
                r_radius <= i_cfg_data[RADIUS_W-1:0];
            end
            for (int s = 0; s < NUM_SECTORS; s++) begin
                if (i_cfg_index == CFG_IDX_W'(int'(CFG_SECTOR0_LOW) + 2 * s)) begin
                    r_sec_lo[s] <= signed'(i_cfg_data[ANGLE_W-1:0]);
                end
                if (i_cfg_index == CFG_IDX_W'(int'(CFG_SECTOR0_LOW) + 2 * s + 1)) begin
                    r_sec_hi[s] <= signed'(i_cfg_data[ANGLE_W-1:0]);
                end
            end
        end
    end

    lpsr_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (in_take),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_radius  (r_radius),
        .o_valid   (prep_valid),
        .o_big     (prep_big),
        .o_small   (prep_small),
        .o_side    (prep_side)
    );

    lpsr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_valid),
        .i_big   (prep_big),
        .i_small (prep_small),
        .i_side  (prep_side),
        .o_valid (cord_valid),
        .o_z     (cord_z),
        .o_side  (cord_side)
    );

    lpsr_post #(
        .NUM_SECTORS (NUM_SECTORS)
    ) u_post (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (cord_valid),
        .i_z                 (cord_z),
        .i_side              (cord_side),
        .i_sector_count      (r_sector_count),
        .i_sec_lo            (r_sec_lo),
        .i_sec_hi            (r_sec_hi),
        .o_valid             (o_result_valid),
        .o_keep_point        (o_keep_point),
        .o_dropped_by_sector (o_dropped_by_sector),
        .o_dropped_by_radius (o_dropped_by_radius),
        .o_bearing           (o_bearing)
    );

endmodule

`default_nettype wire

// ===== hdl/lpsr_prep.sv =====
// lpsr_prep: abs value, octant fold and squared range test, three stages
// depends on lpsr_pkg
`default_nettype none

module lpsr_prep (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic signed [lpsr_pkg::COORD_W-1:0]  i_point_x,
    input  wire logic signed [lpsr_pkg::COORD_W-1:0]  i_point_y,
    input  wire logic [lpsr_pkg::RADIUS_W-1:0]  i_radius,
    output logic                                o_valid,
    output logic [lpsr_pkg::COORD_W-1:0]        o_big,
    output logic [lpsr_pkg::COORD_W-1:0]        o_small,
    output lpsr_pkg::t_side                     o_side
);
    import lpsr_pkg::*;

    logic                 r_v1, r_v2, r_v3;
    logic [COORD_W-1:0]   r_ax, r_ay;
    logic                 r_xneg1, r_yneg1;
    logic [COORD_W-1:0]   n_ax, n_ay;

    logic [COORD_W-1:0]   r_big2, r_small2;
    logic                 r_xneg2, r_yneg2, r_swap2;
    logic [SQ_W-1:0]      r_sqx, r_sqy, r_sqr;
    logic                 n_swap;

    logic [COORD_W-1:0]   r_big3, r_small3;
    t_side                r_side3;
    logic                 n_by_radius;

    always_comb begin
        n_ax = i_point_x[COORD_W-1] ? COORD_W'(-i_point_x) : COORD_W'(i_point_x);
        n_ay = i_point_y[COORD_W-1] ? COORD_W'(-i_point_y) : COORD_W'(i_point_y);
    end

    assign n_swap = r_ay > r_ax;
    assign n_by_radius = ({1'b0, r_sqx} + {1'b0, r_sqy}) < {1'b0, r_sqr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax    <= n_ax;
        r_ay    <= n_ay;
        r_xneg1 <= i_point_x[COORD_W-1];
        r_yneg1 <= i_point_y[COORD_W-1];

        r_big2   <= n_swap ? r_ay : r_ax;
        r_small2 <= n_swap ? r_ax : r_ay;
        r_swap2  <= n_swap;
        r_xneg2  <= r_xneg1;
        r_yneg2  <= r_yneg1;
        r_sqx    <= r_ax * r_ax;
        r_sqy    <= r_ay * r_ay;
        r_sqr    <= i_radius * i_radius;

        r_big3            <= r_big2;
        r_small3          <= r_small2;
        r_side3.xneg      <= r_xneg2;
        r_side3.yneg      <= r_yneg2;
        r_side3.swapped   <= r_swap2;
        r_side3.by_radius <= n_by_radius;
    end

    assign o_valid = r_v3;
    assign o_big   = r_big3;
    assign o_small = r_small3;
    assign o_side  = r_side3;

endmodule

`default_nettype wire

// ===== hdl/lpsr_cordic.sv =====
// lpsr_cordic: vectoring cordic, one rotation per register stage
// depends on lpsr_pkg for widths and the angle table
`default_nettype none

module lpsr_cordic (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic [lpsr_pkg::COORD_W-1:0]   i_big,
    input  wire logic [lpsr_pkg::COORD_W-1:0]   i_small,
    input  wire lpsr_pkg::t_side                i_side,
    output logic                                o_valid,
    output logic signed [lpsr_pkg::ZW-1:0]      o_z,
    output lpsr_pkg::t_side                     o_side
);
    import lpsr_pkg::*;

    logic                 r_v  [CORDIC_ITERS];
    logic signed [XW-1:0] r_cx [CORDIC_ITERS];
    logic signed [XW-1:0] r_cy [CORDIC_ITERS];
    logic signed [ZW-1:0] r_cz [CORDIC_ITERS];
    t_side                r_sd [CORDIC_ITERS];

    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
        localparam logic signed [ZW-1:0] ANG = cordic_angle(i);

        logic                 v_in;
        logic signed [XW-1:0] x_in, y_in;
        logic signed [ZW-1:0] z_in;
        t_side                s_in;
        logic signed [XW-1:0] n_cx, n_cy;
        logic signed [ZW-1:0] n_cz;

        if (i == 0) begin : g_first
            assign v_in = i_valid;
            assign x_in = signed'(XW'({i_big, {PRE_SHIFT{1'b0}}}));
            assign y_in = signed'(XW'({i_small, {PRE_SHIFT{1'b0}}}));
            assign z_in = '0;
            assign s_in = i_side;
        end else begin : g_next
            assign v_in = r_v[i-1];
            assign x_in = r_cx[i-1];
            assign y_in = r_cy[i-1];
            assign z_in = r_cz[i-1];
            assign s_in = r_sd[i-1];
        end

        always_comb begin
            if (y_in > 0) begin
                n_cx = x_in + (y_in >>> i);
                n_cy = y_in - (x_in >>> i);
                n_cz = z_in + ANG;
            end else begin
                n_cx = x_in - (y_in >>> i);
                n_cy = y_in + (x_in >>> i);
                n_cz = z_in - ANG;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else begin
                r_v[i] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_cx[i] <= n_cx;
            r_cy[i] <= n_cy;
            r_cz[i] <= n_cz;
            r_sd[i] <= s_in;
        end
    end

    assign o_valid = r_v[CORDIC_ITERS-1];
    assign o_z     = r_cz[CORDIC_ITERS-1];
    assign o_side  = r_sd[CORDIC_ITERS-1];

endmodule

`default_nettype wire

// ===== hdl/lpsr_post.sv =====
// lpsr_post: bearing rounding and clamp, quadrant unfold, sector test, result register
// depends on lpsr_pkg
`default_nettype none

module lpsr_post #(
    parameter int NUM_SECTORS = 3
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire logic signed [lpsr_pkg::ZW-1:0]     i_z,
    input  wire lpsr_pkg::t_side                    i_side,
    input  wire logic [lpsr_pkg::SECTOR_CNT_W-1:0]  i_sector_count,
    input  wire logic signed [lpsr_pkg::ANGLE_W-1:0] i_sec_lo [NUM_SECTORS],
    input  wire logic signed [lpsr_pkg::ANGLE_W-1:0] i_sec_hi [NUM_SECTORS],
    output logic                                    o_valid,
    output logic                                    o_keep_point,
    output logic                                    o_dropped_by_sector,
    output logic                                    o_dropped_by_radius,
    output logic signed [lpsr_pkg::ANGLE_W-1:0]     o_bearing
);
    import lpsr_pkg::*;

    localparam logic signed [ZW-1:0]   HALF_LSB = ZW'(1) <<< (ANG_FRAC - 1);
    localparam logic signed [ZB_W-1:0] OCT_MAX  = ZB_W'(ANG_OCTANT);

    logic                      r_v1, r_v2, r_v3;
    logic [OCT_W-1:0]          r_b1;
    t_side                     r_sd1, r_sd2;
    logic signed [ANGLE_W-1:0] r_b2;
    logic                      r_keep, r_by_sector, r_by_radius;
    logic signed [ANGLE_W-1:0] r_b3;

    logic signed [ZW-1:0]      n_zr;
    logic signed [ZB_W-1:0]    n_zb;
    logic [OCT_W-1:0]          n_b1;
    logic signed [ANGLE_W-1:0] n_oct, n_t1, n_t2, n_b2;
    logic                      n_hit;

    always_comb begin
        n_zr = i_z + HALF_LSB;
        n_zb = signed'(n_zr[ZW-1:ANG_FRAC]);
        if (n_zb < 0) begin
            n_b1 = '0;
        end else if (n_zb > OCT_MAX) begin
            n_b1 = OCT_W'(ANG_OCTANT);
        end else begin
            n_b1 = n_zb[OCT_W-1:0];
        end
    end

    always_comb begin
        n_oct = signed'(ANGLE_W'(r_b1));
        n_t1  = r_sd1.swapped ? ANGLE_W'(ANG_QUARTER) - n_oct : n_oct;
        n_t2  = r_sd1.xneg ? ANGLE_W'(ANG_HALF) - n_t1 : n_t1;
        n_b2  = r_sd1.yneg ? -n_t2 : n_t2;
    end

    always_comb begin
        n_hit = 1'b0;
        for (int s = 0; s < NUM_SECTORS; s++) begin
            if ((i_sector_count > SECTOR_CNT_W'(s)) && (r_b2 >= i_sec_lo[s])
                    && (r_b2 <= i_sec_hi[s])) begin
                n_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1        <= n_b1;
        r_sd1       <= i_side;
        r_b2        <= n_b2;
        r_sd2       <= r_sd1;
        r_by_sector <= n_hit;
        r_by_radius <= r_sd2.by_radius;
        r_keep      <= ~(n_hit | r_sd2.by_radius);
        r_b3        <= r_b2;
    end

    assign o_valid             = r_v3;
    assign o_keep_point        = r_keep;
    assign o_dropped_by_sector = r_by_sector;
    assign o_dropped_by_radius = r_by_radius;
    assign o_bearing           = r_b3;

endmodule

`default_nettype wire
